// File: src/tti_pkg.sv
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types and constants for the time table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package tti_pkg;
  localparam int unsigned TableRowsDef = 256;
  localparam int unsigned SpeciesCountDef = 8;
  localparam int unsigned ValW = 32;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [3:0] ColTime = 4'd0;
  localparam logic [3:0] ColTemp = 4'd1;
  localparam logic [3:0] ColSpeciesLast = 4'd9;

  localparam logic [1:0] FlagInside = 2'd0;
  localparam logic [1:0] FlagAbove  = 2'd1;
  localparam logic [1:0] FlagBelow  = 2'd2;

  localparam logic [0:0] RegRows = 1'b0;
  localparam logic [0:0] RegCols = 1'b1;

  typedef enum logic [3:0] {
    StIdle, StRdLast, StRdFirst, StChkLast, StChkFirst, StScan, StScanChk,
    StRdPrev, StPrevChk, StDiv, StRdT0, StRdT1, StMul0, StMul1, StSpec, StOut
  } state_e;
endpackage
`default_nettype wire

// File: src/tti_ram.sv
// ----------------------------------------------------------------------------
// tti_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tti_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: src/time_table_interpolator.sv
// ----------------------------------------------------------------------------
// time_table_interpolator
// Table of time rows with linear search and temperature interpolation.
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | payload
// command  | in        | start_i & !busy_o    | opcode, row, column, value, time
// result   | out       | done_o strobe        | rank, flag, temperature, species
// config   | in        | cfg_valid_i&ready_o  | cfg_index_i, cfg_data_i
// A load is taken without raising busy_o. A query holds busy_o while it checks
// the end rows, scans rows (a read and a compare state per searched row) and
// checks the previous row unless clamped, divides at one quotient bit per cycle
// and runs the multiply states when blending, and then reads every species.
// done_o rises in the same cycle that busy_o drops. Reset clears control state
// only; table contents are undefined until written. Results cannot be
// stalled: done_o is high for one cycle.
`default_nettype none
module time_table_interpolator
  import tti_pkg::*;
#(
  parameter int unsigned TableRows    = TableRowsDef,
  parameter int unsigned SpeciesCount = SpeciesCountDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output      logic             busy_o,
  input  wire logic             opcode_i,
  input  wire logic [7:0]       row_index_i,
  input  wire logic [3:0]       column_index_i,
  input  wire logic [31:0]      load_value_i,
  input  wire logic [31:0]      query_time_i,
  input  wire logic             cfg_valid_i,
  output      logic             cfg_ready_o,
  input  wire logic [0:0]       cfg_index_i,
  input  wire logic [8:0]       cfg_data_i,
  output      logic             done_o,
  output      logic [7:0]       found_rank_o,
  output      logic [1:0]       range_flag_o,
  output      logic [31:0]      temperature_o,
  output      logic [31:0]      nucleation_fraction_o,
  output      logic [31:0]      ring1_fraction_o,
  output      logic [31:0]      ring2_fraction_o,
  output      logic [31:0]      ring3_fraction_o,
  output      logic [31:0]      ring4_fraction_o,
  output      logic [31:0]      acetylene_fraction_o,
  output      logic [31:0]      oxygen_fraction_o,
  output      logic [31:0]      hydroxyl_fraction_o
);
  localparam int unsigned RowW = $clog2(TableRows);
  localparam int unsigned SpW  = (SpeciesCount > 1) ? $clog2(SpeciesCount) : 1;
  localparam int unsigned SpDepth = TableRows * SpeciesCount;
  localparam int unsigned SpAW = $clog2(SpDepth);
  localparam int unsigned CntW = RowW + 1;

  state_e state_q, state_d;
  logic [8:0] rows_q, cols_q;
  logic [31:0] q_q, t1_q, den_q, lo_q, res_q;
  logic [63:0] rem_q, acc_q;
  logic [31:0] w_q;
  logic [6:0] bit_q;
  logic [RowW-1:0] rank_q, last_q;
  logic [1:0] flag_q;
  logic [3:0] sp_q;
  logic [31:0] spec_q [8];
  logic interp_q, done_q;

  // rows_in_use clamped to 1..TableRows
  logic [CntW-1:0] act_rows;
  always_comb begin
    if (rows_q == 9'd0) act_rows = CntW'(1);
    else if (32'(rows_q) > TableRows) act_rows = CntW'(TableRows);
    else act_rows = CntW'(rows_q);
  end

  logic we_ok, acc_cmd;
  assign acc_cmd = start_i && !busy_o;
  assign we_ok = acc_cmd && opcode_i == OpLoad && 32'(row_index_i) < TableRows;
  logic t_we, tp_we, s_we;
  logic [3:0] sidx;
  assign sidx = column_index_i - 4'd2;
  assign t_we  = we_ok && column_index_i == ColTime;
  assign tp_we = we_ok && column_index_i == ColTemp;
  assign s_we  = we_ok && column_index_i > ColTemp && column_index_i <= ColSpeciesLast
                 && 32'(sidx) < SpeciesCount;

  logic [RowW-1:0] t_ra, tp_ra;
  logic [SpAW-1:0] s_ra, s_wa;
  logic [31:0] t_rd, tp_rd, s_rd;
  assign s_wa = SpAW'(32'(row_index_i[RowW-1:0]) * SpeciesCount + 32'(sidx));
  assign s_ra = SpAW'(32'(rank_q) * SpeciesCount + 32'(sp_q));

  tti_ram #(.Width(ValW), .Depth(TableRows)) u_time (
    .clk_i, .we_i(t_we), .waddr_i(row_index_i[RowW-1:0]), .wdata_i(load_value_i),
    .raddr_i(t_ra), .rdata_o(t_rd));
  tti_ram #(.Width(ValW), .Depth(TableRows)) u_temp (
    .clk_i, .we_i(tp_we), .waddr_i(row_index_i[RowW-1:0]), .wdata_i(load_value_i),
    .raddr_i(tp_ra), .rdata_o(tp_rd));
  tti_ram #(.Width(ValW), .Depth(SpDepth)) u_spec (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(load_value_i),
    .raddr_i(s_ra), .rdata_o(s_rd));

  // shared unit: 33-bit subtract used by divider; 32x32 multiply for blend
  logic [32:0] sub_r;
  assign sub_r = {rem_q[63:32], rem_q[31]} - {1'b0, den_q};
  logic [63:0] prod;
  assign prod = 64'((state_q == StMul0) ? lo_q : tp_rd) * 64'(w_q);

  always_comb begin
    state_d = state_q;
    t_ra = rank_q;
    tp_ra = rank_q;
    case (state_q)
      StIdle:    if (acc_cmd && opcode_i == OpQuery) state_d = StRdLast;
      StRdLast:  begin t_ra = last_q; state_d = StRdFirst; end
      StRdFirst: begin t_ra = '0; state_d = StChkLast; end
      StChkLast: begin t_ra = '0; state_d = StChkFirst; end
      StChkFirst: state_d = (flag_q == FlagAbove) ? StRdT1 :
                            (q_q < t_rd) ? StRdT1 : StScan;
      StScan:    state_d = StScanChk;
      StScanChk: state_d = (rank_q < last_q && t_rd < q_q) ? StScan : StRdPrev;
      StRdPrev:  begin t_ra = rank_q - RowW'(1); state_d = StPrevChk; end
      StPrevChk: state_d = (interp_q && t_rd < q_q) ? StDiv : StRdT1;
      StDiv:     if (bit_q == 7'd0) state_d = StRdT0;
      StRdT0:    begin tp_ra = rank_q - RowW'(1); state_d = StRdT1; end
      StRdT1:    state_d = (interp_q) ? StMul0 : StSpec;
      StMul0:    state_d = StMul1;
      StMul1:    state_d = StSpec;
      StSpec:    if (sp_q == 4'd8) state_d = StOut;
      StOut:     state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rows_q <= 9'd1;
      cols_q <= 9'h1FF;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= (state_q == StOut);
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegRows) rows_q <= cfg_data_i;
        else cols_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        q_q <= query_time_i;
        last_q <= RowW'(act_rows - CntW'(1));
        rank_q <= '0;
        sp_q <= '0;
      end
      // time of the last row arrives here
      StRdFirst: begin
        interp_q <= 1'b0;
        if (q_q > t_rd) begin
          flag_q <= FlagAbove; rank_q <= last_q;
        end else flag_q <= FlagInside;
      end
      StChkFirst: if (flag_q != FlagAbove && q_q < t_rd) flag_q <= FlagBelow;
      StScanChk: begin
        if (rank_q < last_q && t_rd < q_q) rank_q <= rank_q + RowW'(1);
        else begin
          t1_q <= t_rd;
          // interpolate only strictly inside with a prior row
          interp_q <= (q_q < t_rd) && (rank_q != '0);
        end
      end
      StPrevChk: begin
        den_q <= t1_q - t_rd;
        rem_q <= {32'(q_q - t_rd), 32'd0};
        w_q <= '0;
        bit_q <= 7'd31;
        if (!(t_rd < q_q)) interp_q <= 1'b0;
      end
      StDiv: begin
        bit_q <= bit_q - 7'd1;
        if (!sub_r[32]) begin
          rem_q <= {sub_r[31:0], rem_q[30:0], 1'b0};
          w_q <= {w_q[30:0], 1'b1};
        end else begin
          rem_q <= {rem_q[62:0], 1'b0};
          w_q <= {w_q[30:0], 1'b0};
        end
      end
      StRdT1: lo_q <= tp_rd;
      StMul0: acc_q <= {lo_q, 32'd0} - prod + 64'h8000_0000;
      StMul1: acc_q <= acc_q + prod;
      StSpec: begin
        sp_q <= sp_q + 4'd1;
        if (sp_q != 4'd0) spec_q[sp_q[2:0] - 3'd1] <= s_rd;
      end
      StOut: begin
        res_q <= interp_q ? acc_q[63:32] : lo_q;
      end
      default: ;
    endcase
  end
  // StRdT0 leaves tp_rd=T0 in StRdT1 (lo); StMul0 weighs lo by w.
  // Note: tp_ra in StRdT1 is rank, so StMul1 prod uses T1*w.

  logic [31:0] spo [8];
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      spo[i] = (i < SpeciesCount && cols_q[i+1]) ? spec_q[i] : 32'd0;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign done_o = done_q;
  assign found_rank_o = 8'(rank_q);
  assign range_flag_o = flag_q;
  assign temperature_o = cols_q[0] ? res_q : 32'd0;
  assign nucleation_fraction_o = spo[0];
  assign ring1_fraction_o = spo[1];
  assign ring2_fraction_o = spo[2];
  assign ring3_fraction_o = spo[3];
  assign ring4_fraction_o = spo[4];
  assign acetylene_fraction_o = spo[5];
  assign oxygen_fraction_o = spo[6];
  assign hydroxyl_fraction_o = spo[7];

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("busy at done");
  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rank_q <= last_q) else $error("rank past last");
  a_flag_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (range_flag_o == FlagInside || range_flag_o == FlagAbove
                || range_flag_o == FlagBelow)) else $error("bad flag");
endmodule
`default_nettype wire

// File: test/time_table_interpolator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_table_interpolator_test
// Loads time rows cell by cell, queries them under several register settings
// and sender idle rates, and checks every result against a local predictor.
// ----------------------------------------------------------------------------
module time_table_interpolator_test;
  import tti_pkg::*;

  localparam int unsigned Rows = TableRowsDef;
  localparam int unsigned WatchLimit = 20000;

  typedef struct {
    logic [7:0]  rank;
    logic [1:0]  flag;
    logic [31:0] temp;
    logic [31:0] spec[8];
  } lookup_t;

  typedef struct {
    bit          is_cfg;
    logic        op;
    logic [7:0]  row;
    logic [3:0]  col;
    logic [31:0] val;
    logic [31:0] qt;
    bit          typed;
    logic [7:0]  rank;
    logic [1:0]  flag;
    logic [31:0] temp;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        opcode_i = OpLoad;
  logic [7:0]  row_index_i = '0;
  logic [3:0]  column_index_i = '0;
  logic [31:0] load_value_i = '0;
  logic [31:0] query_time_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = RegRows;
  logic [8:0]  cfg_data_i = '0;
  logic        done_o;
  logic [7:0]  found_rank_o;
  logic [1:0]  range_flag_o;
  logic [31:0] temperature_o;
  logic [31:0] spec_o[8];

  // table copy and registers as the block should hold them
  logic [31:0] time_col[Rows];
  logic [31:0] temp_col[Rows];
  logic [31:0] spec_col[Rows][8];
  logic [8:0]  rows_reg;
  logic [8:0]  cols_reg;
  int unsigned filled_rows = 0;

  lookup_t pending_lookups[$];
  int unsigned errors = 0;
  int unsigned loads_sent = 0, queries_sent = 0, results_seen = 0, idle_pct = 0;
  int unsigned quiet_cycles = 0;
  step_t dir_tab[$];

  time_table_interpolator i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .row_index_i, .column_index_i,
    .load_value_i, .query_time_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i, .done_o, .found_rank_o, .range_flag_o, .temperature_o,
    .nucleation_fraction_o(spec_o[0]), .ring1_fraction_o(spec_o[1]),
    .ring2_fraction_o(spec_o[2]), .ring3_fraction_o(spec_o[3]),
    .ring4_fraction_o(spec_o[4]), .acetylene_fraction_o(spec_o[5]),
    .oxygen_fraction_o(spec_o[6]), .hydroxyl_fraction_o(spec_o[7])
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned last_row();
    int unsigned n;
    n = rows_reg;
    if (n == 0) n = 1;
    if (n > Rows) n = Rows;
    return n - 1;
  endfunction

  function automatic logic [31:0] blend(int unsigned rank, logic [31:0] qt);
    logic [31:0] t0, t1;
    logic [63:0] w, lo, hi, acc;
    t1 = time_col[rank];
    if (qt >= t1 || qt <= time_col[0] || rank == 0) return temp_col[rank];
    t0 = time_col[rank-1];
    if (t0 >= qt) return temp_col[rank];
    w = {32'(qt - t0), 32'd0} / {32'd0, 32'(t1 - t0)};
    lo = {32'd0, temp_col[rank-1]};
    hi = {32'd0, temp_col[rank]};
    acc = (lo << 32) - lo * w + hi * w + 64'h8000_0000;
    return acc[63:32];
  endfunction

  function automatic lookup_t lookup_at(logic [31:0] qt);
    lookup_t r;
    int unsigned last, rank;
    last = last_row();
    if (qt > time_col[last]) begin
      rank = last;
      r.flag = FlagAbove;
    end else if (qt < time_col[0]) begin
      rank = 0;
      r.flag = FlagBelow;
    end else begin
      rank = 0;
      while (rank < last && time_col[rank] < qt) rank++;
      r.flag = FlagInside;
    end
    r.rank = rank[7:0];
    r.temp = cols_reg[0] ? blend(rank, qt) : 32'd0;
    for (int s = 0; s < 8; s++) r.spec[s] = cols_reg[s+1] ? spec_col[rank][s] : 32'd0;
    return r;
  endfunction

  // drive one beat and hold it until the block takes it
  task automatic send_beat(input logic op, input logic [7:0] row, input logic [3:0] col,
                           input logic [31:0] val, input logic [31:0] qt,
                           input bit typed = 0, input logic [7:0] t_rank = '0,
                           input logic [1:0] t_flag = '0, input logic [31:0] t_temp = '0);
    lookup_t r;
    start_i <= 1'b1;
    opcode_i <= op;
    row_index_i <= row;
    column_index_i <= col;
    load_value_i <= val;
    query_time_i <= qt;
    do @(posedge clk_i); while (busy_o);
    if (op == OpQuery) begin
      r = lookup_at(qt);
      if (typed) begin
        r.rank = t_rank;
        r.flag = t_flag;
        r.temp = t_temp;
      end
      pending_lookups = {pending_lookups, r};
      queries_sent++;
    end else begin
      loads_sent++;
      if (col == ColTime) time_col[row] = val;
      else if (col == ColTemp) temp_col[row] = val;
      else if (col <= ColSpeciesLast) spec_col[row][col - ColTemp - 1] = val;
    end
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (busy_o || pending_lookups.size() != 0) @(posedge clk_i);
    // loads leave no result; give any trailing work time to settle
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [8:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegRows) rows_reg = data;
    else cols_reg = data;
  endtask

  // write rows up to n-1, times ascending from the last filled row;
  // species cells only when asked, for phases that mask every species
  task automatic fill_rows(input int unsigned n, input bit plain, input bit species);
    logic [31:0] t;
    t = (filled_rows == 0) ? (plain ? 32'd100 : $urandom_range(0, 1 << 20))
                           : time_col[filled_rows-1];
    for (int unsigned r = filled_rows; r < n; r++) begin
      if (plain) t = 100 * (r + 1);
      else if (r != 0) t = t + $urandom_range(1, 1 << 23);
      send_beat(OpLoad, r[7:0], ColTime, t, '0);
      send_beat(OpLoad, r[7:0], ColTemp, plain ? (2 * r + 1) << 16 : $urandom(), '0);
      if (species)
        for (int s = 0; s < 8; s++)
          send_beat(OpLoad, r[7:0], 4'(ColTemp + 1 + s), plain ? 32'h1000 + r * 8 + s
                    : $urandom(), '0);
    end
    if (n > filled_rows) filled_rows = n;
  endtask

  function automatic logic [31:0] pick_time(int unsigned last);
    int unsigned r;
    r = $urandom_range(0, last);
    case ($urandom_range(5))
      0: return time_col[r];
      1: return time_col[r] + 1;
      2: return time_col[r] - $urandom_range(1, 3);
      3: return (r < last) ? (time_col[r] >> 1) + (time_col[r+1] >> 1) : time_col[r];
      4: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_phase(input logic [8:0] rows, input logic [8:0] cols,
                           input int unsigned pct, input int unsigned items);
    int unsigned need, last, k;
    idle_pct = 0;
    need = (rows == 0) ? 1 : (rows > Rows ? Rows : rows);
    fill_rows(need, 0, cols[8:1] != 8'd0);
    write_reg(RegRows, rows);
    write_reg(RegCols, cols);
    idle_pct = pct;
    last = last_row();
    for (int unsigned i = 0; i < items; i++) begin
      k = $urandom_range(99);
      if (k < 70) begin
        send_beat(OpQuery, 8'($urandom()), 4'($urandom()), $urandom(), pick_time(last));
      end else if (k < 90) begin
        // rewrite a filled cell; time rewrites may break the ascending order
        send_beat(OpLoad, 8'($urandom_range(0, filled_rows - 1)), 4'($urandom_range(0, 9)),
                  $urandom(), $urandom());
      end else begin
        send_beat(OpLoad, 8'($urandom()), 4'($urandom_range(10, 15)), $urandom(),
                  $urandom());
      end
      if (i == items / 2 && pct != 0) drain();
    end
  endtask

  // result check and watchdog
  always @(posedge clk_i) begin
    lookup_t e;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("%0t: no progress for %0d cycles", $time, WatchLimit);
        $display("time_table_interpolator verification failed");
        $finish;
      end
      if (done_o) begin
        results_seen++;
        if (pending_lookups.size() == 0) begin
          $display("%0t: result with none expected, rank %0d", $time, found_rank_o);
          errors++;
        end else begin
          e = pending_lookups.pop_front();
          if (found_rank_o !== e.rank) begin
            $display("%0t: found_rank exp %0d got %0d", $time, e.rank, found_rank_o);
            errors++;
          end
          if (range_flag_o !== e.flag) begin
            $display("%0t: range_flag exp %0d got %0d", $time, e.flag, range_flag_o);
            errors++;
          end
          if (temperature_o !== e.temp) begin
            $display("%0t: temperature exp %h got %h", $time, e.temp, temperature_o);
            errors++;
          end
          for (int s = 0; s < 8; s++)
            if (spec_o[s] !== e.spec[s]) begin
              $display("%0t: species %0d exp %h got %h", $time, s, e.spec[s], spec_o[s]);
              errors++;
            end
        end
      end
    end
  end

  initial begin
    rows_reg = 9'd1;
    cols_reg = 9'h1FF;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rows 0 and 1: times 100 and 200, temperatures 1.0 and 3.0 kelvin
    fill_rows(2, 1, 1);
    dir_tab = '{
      '{0, OpQuery, 0, 0, 0, 32'd50,  1, 0, FlagBelow,  32'h1_0000},
      '{0, OpQuery, 0, 0, 0, 32'd100, 1, 0, FlagInside, 32'h1_0000},
      '{0, OpQuery, 0, 0, 0, 32'd150, 1, 0, FlagAbove,  32'h1_0000},
      '{1, OpLoad,  0, RegRows, 9'd2, 0, 0, 0, 0, 0},
      '{0, OpQuery, 0, 0, 0, 32'd0,   1, 0, FlagBelow,  32'h1_0000},
      '{0, OpQuery, 0, 0, 0, 32'd150, 1, 1, FlagInside, 32'h2_0000},
      '{0, OpQuery, 0, 0, 0, 32'd200, 1, 1, FlagInside, 32'h3_0000},
      '{0, OpQuery, 0, 0, 0, 32'd201, 1, 1, FlagAbove,  32'h3_0000},
      '{0, OpQuery, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, FlagAbove, 32'h3_0000},
      '{0, OpQuery, 0, 0, 0, 32'd101, 0, 0, 0, 0},
      '{0, OpLoad, 8'd1, 4'd15, 32'hDEAD_BEEF, 0, 0, 0, 0, 0},
      '{0, OpLoad, 8'd0, 4'd10, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
      '{0, OpQuery, 0, 0, 0, 32'd199, 0, 0, 0, 0},
      '{0, OpLoad, 8'd1, ColTime, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
      '{0, OpQuery, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, FlagInside, 32'h3_0000},
      '{0, OpQuery, 0, 0, 0, 32'hFFFF_FFFE, 0, 0, 0, 0},
      '{0, OpLoad, 8'd0, ColTime, 32'd0, 0, 0, 0, 0, 0},
      '{0, OpQuery, 0, 0, 0, 32'd0, 1, 0, FlagInside, 32'h1_0000},
      '{0, OpLoad, 8'd0, ColTemp, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
      '{0, OpLoad, 8'd1, ColTemp, 32'd0, 0, 0, 0, 0, 0},
      '{0, OpQuery, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0},
      '{1, OpLoad,  0, RegCols, 9'd0, 0, 0, 0, 0, 0},
      '{0, OpQuery, 0, 0, 0, 32'd7, 1, 1, FlagInside, 32'd0},
      '{1, OpLoad,  0, RegCols, 9'h1FF, 0, 0, 0, 0, 0}
    };
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].col[0], dir_tab[i].val[8:0]);
      else send_beat(dir_tab[i].op, dir_tab[i].row, dir_tab[i].col, dir_tab[i].val,
                     dir_tab[i].qt, dir_tab[i].typed, dir_tab[i].rank, dir_tab[i].flag,
                     dir_tab[i].temp);
    end

    run_phase(9'd5,   9'h1FF, 0,  100);
    run_phase(9'd0,   9'h000, 67, 80);
    run_phase(9'd16,  9'h155, 67, 100);
    run_phase(9'd40,  9'h0AA, 30, 100);
    run_phase(9'd511, 9'h001, 30, 80);
    run_phase(9'd256, 9'h001, 0,  80);
    run_phase(9'd8,   9'h1FE, 30, 100);

    drain();
    $display("covered %0d loads and %0d queries, %0d results checked",
             loads_sent, queries_sent, results_seen);
    $display("row counts 0 to 511, column masks empty to full, idle rates 0 to 67 pct");
    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("time_table_interpolator verification clean");
    end else begin
      $display("time_table_interpolator verification failed");
    end
    $finish;
  end
endmodule
